/* rtl/bcpm_pkg.sv */
// ----------------------------------------------------------------------------
// bcpm_pkg
// Shared types and constants of the battery cell protection monitor.
// ----------------------------------------------------------------------------
package bcpm_pkg;

	// field widths
	localparam int VOLT_W    = 15;
	localparam int CURR_W    = 16;
	localparam int TEMP_W    = 12;
	localparam int IDX_W     = 2;
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 3;

	// stream payload widths
	localparam int S_DATA_W = 48;
	localparam int S_USER_W = 5;
	localparam int M_DATA_W = 72;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OVER_VOLT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UNDER_VOLT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OVER_CURR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OVER_TEMP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_BAND  = 3'd4;

	// configuration reset values
	localparam logic [VOLT_W-1:0] OVER_VOLT_RST  = 15'd4200;
	localparam logic [VOLT_W-1:0] UNDER_VOLT_RST = 15'd3000;
	localparam logic [CFG_W-1:0]  OVER_CURR_RST  = 15'd2000;
	localparam logic [TEMP_W-1:0] OVER_TEMP_RST  = 12'd960;
	localparam logic [CFG_W-1:0]  IDLE_BAND_RST  = 15'd50;

	// per-cell record reset values
	localparam logic [VOLT_W-1:0] MIN_VOLT_RST = 15'h7FFF;
	localparam logic [CURR_W-1:0] MIN_CURR_RST = 16'd10000;

	// system mode codes as seen on the result stream
	localparam logic [1:0] SYS_IDLE        = 2'd0;
	localparam logic [1:0] SYS_CHARGING    = 2'd1;
	localparam logic [1:0] SYS_DISCHARGING = 2'd2;
	localparam logic [1:0] SYS_FAULT       = 2'd3;

	// mode machine states
	typedef enum logic [3:0] {
		MODE_IDLE        = 4'b0001,
		MODE_CHARGING    = 4'b0010,
		MODE_DISCHARGING = 4'b0100,
		MODE_FAULT       = 4'b1000
	} mode_t;

	// one cell sample
	typedef struct packed {
		logic              bus_ok;
		logic              temp_ok;
		logic              gauge_ok;
		logic [VOLT_W-1:0] voltage;
		logic [CURR_W-1:0] current;
		logic [TEMP_W-1:0] temp;
	} sample_t;

	// fault flag, last current and records of one cell
	typedef struct packed {
		logic              fault;
		logic [CURR_W-1:0] last_current;
		logic [VOLT_W-1:0] volt_max;
		logic [VOLT_W-1:0] volt_min;
		logic [CURR_W-1:0] curr_max;
		logic [CURR_W-1:0] curr_min;
	} cell_stat_t;

	// per-item control into the mode machine
	typedef struct packed {
		logic in_range;
		logic reads_ok;
		logic unsafe;
		logic round_end;
	} mode_ctl_t;

	// stream code of a mode state
	function automatic logic [1:0] mode_code(mode_t m);
		logic [1:0] code;
		case (m)
			MODE_IDLE:        code = SYS_IDLE;
			MODE_CHARGING:    code = SYS_CHARGING;
			MODE_DISCHARGING: code = SYS_DISCHARGING;
			MODE_FAULT:       code = SYS_FAULT;
			default:          code = SYS_IDLE;
		endcase
		return code;
	endfunction

endpackage

/* rtl/battery_cell_protection_monitor.sv */
// ----------------------------------------------------------------------------
// battery_cell_protection_monitor
// Per-cell fault detection, min/max records, load switch and mode machine.
// ----------------------------------------------------------------------------
// Takes one cell sample per item and returns one result per item. An accepted
// item sits in the input register, where the threshold compares, record
// updates, load logic and round-end mode step are worked out, and is then
// written into the result register; the cell and mode state are updated at
// that same edge. A new item can be accepted in every cycle while the result
// side keeps taking results; a stalled result holds the item behind it in
// the input register. Samples with a cell index of CELL_COUNT or above leave
// all cell and load state alone and return zero records, though a round end
// on them still steps the mode.
module battery_cell_protection_monitor #(
	parameter int CELL_COUNT = 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [bcpm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bcpm_pkg::CFG_W-1:0]        cfg_data,
	// sample stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// cell_voltage_mv[14:0], cell_current_ma[30:15], cell_temp[42:31], zero pad
	input  logic [bcpm_pkg::S_DATA_W-1:0]     s_tdata,
	// cell_index[1:0], bus_ok[2], temp_ok[3], gauge_ok[4]
	input  logic [bcpm_pkg::S_USER_W-1:0]     s_tuser,
	input  logic                              s_tlast,
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// cell_fault[0], load_enable[1], system_mode[3:2], voltage_max_mv[18:4],
	// voltage_min_mv[33:19], current_max_ma[49:34], current_min_ma[65:50],
	// zero pad
	output logic [bcpm_pkg::M_DATA_W-1:0]     m_tdata
);

	// configuration registers
	logic [bcpm_pkg::VOLT_W-1:0] over_volt_q;
	logic [bcpm_pkg::VOLT_W-1:0] under_volt_q;
	logic [bcpm_pkg::CFG_W-1:0]  over_curr_q;
	logic [bcpm_pkg::TEMP_W-1:0] over_temp_q;
	logic [bcpm_pkg::CFG_W-1:0]  idle_band_q;

	// input register
	logic                           vld_s1;
	bcpm_pkg::sample_t              smp_s1;
	logic [bcpm_pkg::IDX_W-1:0]     idx_s1;
	logic                           rend_s1;

	logic                           adv;
	logic                           in_range;
	logic                           unsafe;
	logic [CELL_COUNT-1:0]          sel;
	bcpm_pkg::cell_stat_t           stat [CELL_COUNT];
	bcpm_pkg::cell_stat_t           res_stat;
	logic [CELL_COUNT-1:0][bcpm_pkg::CURR_W-1:0] last_cur;
	logic [CELL_COUNT-1:0]          fault_vec;
	bcpm_pkg::mode_ctl_t            ctl;
	logic                           load_nxt;
	logic [1:0]                     mode_nxt;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_volt_q  <= bcpm_pkg::OVER_VOLT_RST;
			under_volt_q <= bcpm_pkg::UNDER_VOLT_RST;
			over_curr_q  <= bcpm_pkg::OVER_CURR_RST;
			over_temp_q  <= bcpm_pkg::OVER_TEMP_RST;
			idle_band_q  <= bcpm_pkg::IDLE_BAND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bcpm_pkg::REG_OVER_VOLT:  over_volt_q  <= cfg_data;
				bcpm_pkg::REG_UNDER_VOLT: under_volt_q <= cfg_data;
				bcpm_pkg::REG_OVER_CURR:  over_curr_q  <= cfg_data;
				bcpm_pkg::REG_OVER_TEMP:  over_temp_q  <= cfg_data[bcpm_pkg::TEMP_W-1:0];
				bcpm_pkg::REG_IDLE_BAND:  idle_band_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: item leaves the input register when the result slot frees
	assign adv      = vld_s1 && (!m_tvalid || m_tready);
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	// input payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			smp_s1.voltage  <= s_tdata[14:0];
			smp_s1.current  <= s_tdata[30:15];
			smp_s1.temp     <= s_tdata[42:31];
			idx_s1          <= s_tuser[1:0];
			smp_s1.bus_ok   <= s_tuser[2];
			smp_s1.temp_ok  <= s_tuser[3];
			smp_s1.gauge_ok <= s_tuser[4];
			rend_s1         <= s_tlast;
		end
	end

	// threshold compares, all strict
	always_comb begin
		unsafe = (smp_s1.voltage > over_volt_q)
		      || (smp_s1.voltage < under_volt_q)
		      || ($signed(smp_s1.current) > $signed({1'b0, over_curr_q}))
		      || ($signed(smp_s1.temp) > $signed(over_temp_q));
	end

	assign in_range = int'(idx_s1) < CELL_COUNT;

	// per-cell state
	for (genvar c = 0; c < CELL_COUNT; c++) begin : g_cell
		assign sel[c] = (int'(idx_s1) == c);

		bcpm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.sel    (sel[c]),
			.adv    (adv),
			.smp    (smp_s1),
			.unsafe (unsafe),
			.nxt    (stat[c])
		);

		assign last_cur[c]  = stat[c].last_current;
		assign fault_vec[c] = stat[c].fault;
	end

	// addressed cell's records, zero when out of range
	always_comb begin
		res_stat = '0;
		for (int c = 0; c < CELL_COUNT; c++) begin
			if (sel[c]) begin
				res_stat = stat[c];
			end
		end
	end

	assign ctl.in_range  = in_range;
	assign ctl.reads_ok  = smp_s1.bus_ok && smp_s1.temp_ok;
	assign ctl.unsafe    = unsafe;
	assign ctl.round_end = rend_s1;

	bcpm_mode #(
		.CELL_COUNT (CELL_COUNT)
	) u_mode (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.ctl       (ctl),
		.idle_band (idle_band_q),
		.last_cur  (last_cur),
		.fault_vec (fault_vec),
		.load_nxt  (load_nxt),
		.mode_nxt  (mode_nxt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (!m_tvalid || m_tready) begin
			m_tvalid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {6'b000000,
			            res_stat.curr_min,
			            res_stat.curr_max,
			            res_stat.volt_min,
			            res_stat.volt_max,
			            mode_nxt,
			            load_nxt,
			            res_stat.fault};
		end
	end

endmodule

/* rtl/bcpm_cell.sv */
// ----------------------------------------------------------------------------
// bcpm_cell
// State of one cell: fault flag, last current, voltage and current records.
// ----------------------------------------------------------------------------
module bcpm_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sel,
	input  logic                adv,
	input  bcpm_pkg::sample_t   smp,
	input  logic                unsafe,
	output bcpm_pkg::cell_stat_t nxt
);

	bcpm_pkg::cell_stat_t cur_q;

	// state after the current sample, when this cell is addressed
	always_comb begin
		nxt = cur_q;
		if (sel) begin
			if (smp.bus_ok) begin
				nxt.last_current = smp.current;
			end
			if (smp.bus_ok && smp.temp_ok) begin
				if (smp.voltage > cur_q.volt_max) begin
					nxt.volt_max = smp.voltage;
				end
				if (smp.voltage < cur_q.volt_min) begin
					nxt.volt_min = smp.voltage;
				end
				if ($signed(smp.current) > $signed(cur_q.curr_max)) begin
					nxt.curr_max = smp.current;
				end
				if ($signed(smp.current) < $signed(cur_q.curr_min)) begin
					nxt.curr_min = smp.current;
				end
			end
			// a failed read or any breach faults the cell
			nxt.fault = !(smp.bus_ok && smp.temp_ok && smp.gauge_ok && !unsafe);
		end
	end

	// commit when the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.fault        <= 1'b0;
			cur_q.last_current <= '0;
			cur_q.volt_max     <= '0;
			cur_q.volt_min     <= bcpm_pkg::MIN_VOLT_RST;
			cur_q.curr_max     <= '0;
			cur_q.curr_min     <= bcpm_pkg::MIN_CURR_RST;
		end else if (sel && adv) begin
			cur_q <= nxt;
		end
	end

endmodule

/* rtl/bcpm_mode.sv */
// ----------------------------------------------------------------------------
// bcpm_mode
// Load switch logic and the round-end mode machine.
// ----------------------------------------------------------------------------
module bcpm_mode #(
	parameter int CELL_COUNT = 3
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        adv,
	input  bcpm_pkg::mode_ctl_t                         ctl,
	input  logic [bcpm_pkg::CFG_W-1:0]                  idle_band,
	input  logic [CELL_COUNT-1:0][bcpm_pkg::CURR_W-1:0] last_cur,
	input  logic [CELL_COUNT-1:0]                       fault_vec,
	output logic                                        load_nxt,
	output logic [1:0]                                  mode_nxt
);

	bcpm_pkg::mode_t mode_q;
	bcpm_pkg::mode_t mode_n;
	logic            load_q;
	logic            flag_q;
	logic            flag_n;
	logic            load_n;

	logic signed [bcpm_pkg::CURR_W:0] band_s;
	logic signed [bcpm_pkg::CURR_W:0] cur_s;
	logic                             dir_hit;
	logic                             dir_chg;

	// first cell past the deadband picks the direction
	always_comb begin
		band_s  = $signed({2'b00, idle_band});
		dir_hit = 1'b0;
		dir_chg = 1'b0;
		cur_s   = '0;
		for (int c = CELL_COUNT - 1; c >= 0; c--) begin
			cur_s = $signed({last_cur[c][bcpm_pkg::CURR_W-1], last_cur[c]});
			if (cur_s < -band_s) begin
				dir_hit = 1'b1;
				dir_chg = 1'b1;
			end else if (cur_s > band_s) begin
				dir_hit = 1'b1;
				dir_chg = 1'b0;
			end
		end
	end

	// load switch and mode after this item
	always_comb begin
		load_n = load_q;
		flag_n = flag_q;
		mode_n = mode_q;
		if (ctl.in_range && ctl.reads_ok) begin
			if (ctl.unsafe && flag_q) begin
				load_n = 1'b0;
				flag_n = 1'b0;
			end else if (!ctl.unsafe && !flag_q) begin
				load_n = 1'b1;
				flag_n = 1'b1;
			end
		end
		if (ctl.round_end) begin
			case (mode_q)
				bcpm_pkg::MODE_IDLE: begin
					if (dir_hit) begin
						mode_n = dir_chg ? bcpm_pkg::MODE_CHARGING
						                 : bcpm_pkg::MODE_DISCHARGING;
					end
				end
				bcpm_pkg::MODE_CHARGING, bcpm_pkg::MODE_DISCHARGING: begin
					if (|fault_vec) begin
						mode_n = bcpm_pkg::MODE_FAULT;
					end
				end
				bcpm_pkg::MODE_FAULT: begin
					load_n = 1'b0;
				end
				default: begin
					mode_n = mode_q;
				end
			endcase
		end
	end

	assign load_nxt = load_n;
	assign mode_nxt = bcpm_pkg::mode_code(mode_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bcpm_pkg::MODE_IDLE;
			load_q <= 1'b1;
			flag_q <= 1'b1;
		end else if (adv) begin
			mode_q <= mode_n;
			load_q <= load_n;
			flag_q <= flag_n;
		end
	end

endmodule

/* rtl/bcpm_checker.sv */
// ----------------------------------------------------------------------------
// bcpm_checker
// Port-level checks of the battery cell protection monitor.
// ----------------------------------------------------------------------------
module bcpm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [bcpm_pkg::M_DATA_W-1:0]     m_tdata
);

	logic out_acc;
	logic left_idle_q;
	logic fault_seen_q;

	assign out_acc = m_tvalid && m_tready;

	// remember what results have shown so far
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_idle_q  <= 1'b0;
			fault_seen_q <= 1'b0;
		end else if (out_acc) begin
			if (m_tdata[3:2] != bcpm_pkg::SYS_IDLE) begin
				left_idle_q <= 1'b1;
			end
			if (m_tdata[3:2] == bcpm_pkg::SYS_FAULT) begin
				fault_seen_q <= 1'b1;
			end
		end
	end

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// idle is never re-entered once left
	a_no_idle_return: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && left_idle_q |-> m_tdata[3:2] != bcpm_pkg::SYS_IDLE)
		else $error("mode returned to idle");

	// fault mode is left only by reset
	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && fault_seen_q |-> m_tdata[3:2] == bcpm_pkg::SYS_FAULT)
		else $error("mode left fault");

endmodule

bind battery_cell_protection_monitor bcpm_checker u_bcpm_checker (.*);

/* verif/cell_report_checker.sv */
// ----------------------------------------------------------------------------
// cell_report_checker
// Watches the configuration port and both streams of the battery cell
// protection monitor. Every accepted sample is run through a local model of
// the per-cell fault, record, load switch and mode logic, and the resulting
// report is queued. Every accepted result is compared field by field with the
// oldest queued report.
// ----------------------------------------------------------------------------
module cell_report_checker import bcpm_pkg::*; #(
	parameter int CELL_COUNT = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	// cell_voltage_mv[14:0], cell_current_ma[30:15], cell_temp[42:31], zero pad
	input  logic [S_DATA_W-1:0]   s_tdata,
	// cell_index[1:0], bus_ok[2], temp_ok[3], gauge_ok[4]
	input  logic [S_USER_W-1:0]   s_tuser,
	input  logic                  s_tlast,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// cell_fault[0], load_enable[1], system_mode[3:2], voltage_max_mv[18:4],
	// voltage_min_mv[33:19], current_max_ma[49:34], current_min_ma[65:50]
	input  logic [M_DATA_W-1:0]   m_tdata,
	output int                    fail_count,
	output int                    reports_due,
	output int                    results_seen,
	output logic [3:0]            modes_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic              fault;
		logic              load;
		logic [1:0]        mode;
		logic [VOLT_W-1:0] volt_max;
		logic [VOLT_W-1:0] volt_min;
		logic [CURR_W-1:0] curr_max;
		logic [CURR_W-1:0] curr_min;
	} cell_report_t;

	// limits as last written
	logic [VOLT_W-1:0]        ov_limit;
	logic [VOLT_W-1:0]        uv_limit;
	logic [CFG_W-1:0]         oc_limit;
	logic signed [TEMP_W-1:0] ot_limit;
	logic [CFG_W-1:0]         band;

	// monitor state
	logic [1:0]               mode;
	logic                     load_pin;
	logic                     load_flag;
	logic                     fault_flag [CELL_COUNT];
	logic signed [CURR_W-1:0] last_curr  [CELL_COUNT];
	logic [VOLT_W-1:0]        volt_hi    [CELL_COUNT];
	logic [VOLT_W-1:0]        volt_lo    [CELL_COUNT];
	logic signed [CURR_W-1:0] curr_hi    [CELL_COUNT];
	logic signed [CURR_W-1:0] curr_lo    [CELL_COUNT];

	cell_report_t due_reports [$];
	int           mismatches;
	int           checked;
	logic [3:0]   mode_mask;

	task automatic clear_state();
		ov_limit  = OVER_VOLT_RST;
		uv_limit  = UNDER_VOLT_RST;
		oc_limit  = OVER_CURR_RST;
		ot_limit  = OVER_TEMP_RST;
		band      = IDLE_BAND_RST;
		mode      = SYS_IDLE;
		load_pin  = 1'b1;
		load_flag = 1'b1;
		for (int c = 0; c < CELL_COUNT; c++) begin
			fault_flag[c] = 1'b0;
			last_curr[c]  = '0;
			volt_hi[c]    = '0;
			volt_lo[c]    = MIN_VOLT_RST;
			curr_hi[c]    = '0;
			curr_lo[c]    = MIN_CURR_RST;
		end
		due_reports.delete();
	endtask

	task automatic write_limit(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
		case (index)
			REG_OVER_VOLT:  ov_limit = value;
			REG_UNDER_VOLT: uv_limit = value;
			REG_OVER_CURR:  oc_limit = value;
			REG_OVER_TEMP:  ot_limit = value[TEMP_W-1:0];
			REG_IDLE_BAND:  band = value;
			default: ;
		endcase
	endtask

	// one round-end step of the mode machine
	task automatic step_mode();
		int  lc;
		int  band_i;
		logic picked;
		band_i = band;
		picked = 1'b0;
		case (mode)
			SYS_IDLE: begin
				// first cell past the deadband picks the direction
				for (int c = 0; c < CELL_COUNT; c++) begin
					lc = last_curr[c];
					if (!picked && lc < -band_i) begin
						mode = SYS_CHARGING;
						picked = 1'b1;
					end else if (!picked && lc > band_i) begin
						mode = SYS_DISCHARGING;
						picked = 1'b1;
					end
				end
			end
			SYS_CHARGING, SYS_DISCHARGING: begin
				for (int c = 0; c < CELL_COUNT; c++)
					if (fault_flag[c]) mode = SYS_FAULT;
			end
			default: begin
				// fault mode pulls the pin but leaves the connected flag
				load_pin = 1'b0;
			end
		endcase
	endtask

	// apply one sample to the model and build its report
	task automatic apply_sample(
		input  logic [IDX_W-1:0]  idx,
		input  logic              bus_ok,
		input  logic              temp_ok,
		input  logic              gauge_ok,
		input  logic [VOLT_W-1:0] volt,
		input  logic signed [CURR_W-1:0] curr,
		input  logic signed [TEMP_W-1:0] temp,
		input  logic              rend,
		output cell_report_t      rep
	);
		logic fault;
		logic skip_gauge;
		logic unsafe;
		logic in_range;
		fault = 1'b0;
		skip_gauge = 1'b0;
		in_range = idx < CELL_COUNT;
		if (in_range) begin
			if (bus_ok) begin
				last_curr[idx] = curr;
				if (!temp_ok) begin
					// temperature read lost: fault, nothing else is looked at
					fault = 1'b1;
					skip_gauge = 1'b1;
				end else begin
					if (volt > volt_hi[idx]) volt_hi[idx] = volt;
					if (volt < volt_lo[idx]) volt_lo[idx] = volt;
					if (curr > curr_hi[idx]) curr_hi[idx] = curr;
					if (curr < curr_lo[idx]) curr_lo[idx] = curr;
					unsafe = volt > ov_limit || volt < uv_limit ||
						curr > $signed({1'b0, oc_limit}) || temp > ot_limit;
					if (unsafe) begin
						fault = 1'b1;
						if (load_flag) begin
							load_pin = 1'b0;
							load_flag = 1'b0;
						end
					end else if (!load_flag) begin
						load_pin = 1'b1;
						load_flag = 1'b1;
					end
				end
			end else begin
				fault = 1'b1;
			end
			if (!skip_gauge && !gauge_ok) fault = 1'b1;
			fault_flag[idx] = fault;
		end
		if (rend) step_mode();
		rep.fault = fault;
		rep.load  = load_pin;
		rep.mode  = mode;
		if (in_range) begin
			rep.volt_max = volt_hi[idx];
			rep.volt_min = volt_lo[idx];
			rep.curr_max = curr_hi[idx];
			rep.curr_min = curr_lo[idx];
		end else begin
			rep.volt_max = '0;
			rep.volt_min = '0;
			rep.curr_max = '0;
			rep.curr_min = '0;
		end
	endtask

	task automatic compare_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result(input logic [M_DATA_W-1:0] data);
		cell_report_t want;
		if (due_reports.size() == 0) begin
			$display("%0t: result with no item outstanding, expected none, got %0h",
				$time, data);
			mismatches++;
		end else begin
			want = due_reports.pop_front();
			compare_field("cell_fault", 16'(want.fault), 16'(data[0]));
			compare_field("load_enable", 16'(want.load), 16'(data[1]));
			compare_field("system_mode", 16'(want.mode), 16'(data[3:2]));
			compare_field("voltage_max_mv", 16'(want.volt_max), 16'(data[18:4]));
			compare_field("voltage_min_mv", 16'(want.volt_min), 16'(data[33:19]));
			compare_field("current_max_ma", want.curr_max, data[49:34]);
			compare_field("current_min_ma", want.curr_min, data[65:50]);
			mode_mask[want.mode] = 1'b1;
			checked++;
		end
	endtask

	// watch the ports at each edge, counts go out by nonblocking update
	always @(posedge clk or negedge arst_n) begin
		cell_report_t rep;
		if (!arst_n) begin
			clear_state();
			mismatches = 0;
			checked = 0;
			mode_mask = '0;
			fail_count <= 0;
			reports_due <= 0;
			results_seen <= 0;
			modes_seen <= '0;
		end else begin
			if (cfg_we) write_limit(cfg_index, cfg_data);
			if (s_tvalid && s_tready) begin
				apply_sample(s_tuser[1:0], s_tuser[2], s_tuser[3], s_tuser[4],
					s_tdata[14:0], s_tdata[30:15], s_tdata[42:31], s_tlast, rep);
				due_reports.push_back(rep);
			end
			if (m_tvalid && m_tready) check_result(m_tdata);
			fail_count <= mismatches;
			reports_due <= due_reports.size();
			results_seen <= checked;
			modes_seen <= mode_mask;
		end
	end

endmodule

/* verif/battery_cell_protection_monitor_test.sv */
// ----------------------------------------------------------------------------
// battery_cell_protection_monitor_test
// Drives cell samples and limit settings into the protection monitor and
// checks every result through cell_report_checker. The run walks the mode
// machine from idle through charging or discharging into fault, with limit
// settings changed between phases, bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module battery_cell_protection_monitor_test;
	timeunit 1ns;
	timeprecision 1ps;
	import bcpm_pkg::*;

	localparam int CELLS          = 3;
	localparam int HALF_PERIOD    = 4;
	localparam int QUIET_LIMIT    = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 10;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	// result side stall patterns
	typedef enum int {RX_STEADY, RX_COIN, RX_GAPPED, RX_TRICKLE} rx_style_e;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	// cell_voltage_mv[14:0], cell_current_ma[30:15], cell_temp[42:31], zero pad
	logic [S_DATA_W-1:0]  s_tdata;
	// cell_index[1:0], bus_ok[2], temp_ok[3], gauge_ok[4]
	logic [S_USER_W-1:0]  s_tuser;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	// cell_fault[0], load_enable[1], system_mode[3:2], voltage_max_mv[18:4],
	// voltage_min_mv[33:19], current_max_ma[49:34], current_min_ma[65:50]
	logic [M_DATA_W-1:0]  m_tdata;

	int         fail_count;
	int         reports_due;
	int         results_seen;
	logic [3:0] modes_seen;

	int items_sent;
	int burst_left;
	int read_fail_pct;
	int hold_asks;
	int hold_done;
	int quiet_cycles;

	always #HALF_PERIOD clk = ~clk;

	battery_cell_protection_monitor #(.CELL_COUNT(CELLS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	cell_report_checker #(.CELL_COUNT(CELLS)) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.fail_count   (fail_count),
		.reports_due  (reports_due),
		.results_seen (results_seen),
		.modes_seen   (modes_seen)
	);

	// watchdog on cycles where neither stream moves
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: runs of stall patterns, plus a long hold-off on request
	initial begin
		rx_style_e style;
		int run_len;
		m_tready <= 1'b0;
		hold_done = 0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (hold_asks != hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done++;
			end
			style = rx_style_e'($urandom_range(0, 3));
			run_len = $urandom_range(8, 80);
			for (int k = 0; k < run_len; k++) begin
				// a pending hold-off starts right away
				if (hold_asks != hold_done) break;
				case (style)
					RX_STEADY:  m_tready <= 1'b1;
					RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
					RX_GAPPED:  m_tready <= (k % 4) != 3;
					default:    m_tready <= (k % 5) == 0;
				endcase
				@(posedge clk);
			end
		end
	end

	// offer one sample, with a random gap when a burst runs out
	task automatic send_sample(input logic [IDX_W-1:0] idx, input logic bus_ok,
		input logic temp_ok, input logic gauge_ok, input int volt, input int curr,
		input int temp, input logic rend);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, temp[TEMP_W-1:0], curr[CURR_W-1:0], volt[VOLT_W-1:0]};
		s_tuser  <= {gauge_ok, temp_ok, bus_ok, idx};
		s_tlast  <= rend;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	function automatic int pick_volt();
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return 32767;
			2:       return $urandom_range(0, 32767);
			default: return $urandom_range(2000, 5000);
		endcase
	endfunction

	// full_neg allows the most negative current, which leaves idle under any band
	function automatic int pick_curr(input bit full_neg);
		int v;
		case ($urandom_range(0, 9))
			0:       v = full_neg ? -32768 : -32767;
			1:       v = 32767;
			2:       v = int'($urandom_range(0, 65535)) - 32768;
			default: v = int'($urandom_range(0, 6000)) - 3000;
		endcase
		if (!full_neg && v == -32768) v = -32767;
		return v;
	endfunction

	function automatic int pick_temp();
		case ($urandom_range(0, 9))
			0:       return -2048;
			1:       return 2047;
			2:       return int'($urandom_range(0, 4095)) - 2048;
			default: return int'($urandom_range(0, 1900)) - 300;
		endcase
	endfunction

	task automatic send_random(input logic [IDX_W-1:0] idx, input logic rend,
		input bit full_neg);
		logic bus_ok;
		logic temp_ok;
		logic gauge_ok;
		bus_ok   = $urandom_range(0, 99) >= read_fail_pct;
		temp_ok  = $urandom_range(0, 99) >= read_fail_pct;
		gauge_ok = $urandom_range(0, 99) >= read_fail_pct;
		send_sample(idx, bus_ok, temp_ok, gauge_ok, pick_volt(), pick_curr(full_neg),
			pick_temp(), rend);
	endtask

	// mostly whole rounds in cell order, some stray samples
	task automatic run_rounds(input int count, input bit full_neg);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 9) < 8) begin
				for (int c = 0; c < CELLS; c++)
					send_random(c[IDX_W-1:0], c == CELLS - 1, full_neg);
			end else begin
				send_random(IDX_W'($urandom_range(0, 3)), $urandom_range(0, 3) == 0,
					full_neg);
			end
		end
	endtask

	// stop offering and wait until every result has come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (reports_due != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value[CFG_W-1:0];
		@(posedge clk);
	endtask

	task automatic set_limits(input int ov, input int uv, input int oc, input int ot,
		input int band);
		wait_idle();
		write_reg(REG_OVER_VOLT, ov);
		write_reg(REG_UNDER_VOLT, uv);
		write_reg(REG_OVER_CURR, oc);
		write_reg(REG_OVER_TEMP, ot);
		write_reg(REG_IDLE_BAND, band);
		cfg_we <= 1'b0;
	endtask

	task automatic set_random_limits(input int band);
		set_limits($urandom_range(3500, 4700), $urandom_range(2500, 3500),
			$urandom_range(0, 3000), int'($urandom_range(0, 1800)) - 300, band);
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		s_tvalid      <= 1'b0;
		s_tdata       <= '0;
		s_tuser       <= '0;
		s_tlast       <= 1'b0;
		hold_asks     <= 0;
		quiet_cycles  <= 0;
		items_sent    = 0;
		burst_left    = 0;
		read_fail_pct = 10;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits, currents kept inside the deadband so idle holds
		send_sample(0, 1, 1, 1, 3700, 10, 400, 0);
		send_sample(1, 0, 1, 1, 3600, 20, 400, 0);   // bus read lost
		send_sample(2, 1, 0, 0, 3600, -20, 400, 1);  // temp read lost, gauge ignored
		send_sample(0, 1, 1, 0, 3700, 0, 400, 0);    // gauge read lost
		send_sample(3, 1, 1, 1, 3700, 0, 400, 1);    // cell out of range, round end
		send_sample(1, 1, 1, 1, 32767, -50, -2048, 0);
		send_sample(2, 1, 1, 1, 0, 50, 2047, 1);
		send_sample(0, 1, 1, 1, 3500, 0, 400, 0);    // safe sample reconnects load

		// widest deadband keeps idle; limits sit at their reset values
		set_limits(4200, 3000, 2000, 960, 32767);
		write_reg(REG_SPARE, $urandom_range(0, 32767));
		cfg_we <= 1'b0;
		// compares are strict: values equal to a limit are safe
		send_sample(0, 1, 1, 1, 4200, 2000, 960, 0);
		send_sample(1, 1, 1, 1, 4201, 0, 0, 0);
		send_sample(2, 1, 1, 1, 3000, 0, 0, 1);
		send_sample(0, 1, 1, 1, 2999, 0, 0, 0);
		send_sample(1, 1, 1, 1, 3500, 2001, 0, 0);
		send_sample(2, 1, 1, 1, 3500, 0, 961, 1);
		send_sample(0, 1, 1, 1, 3500, 32767, 0, 0);
		send_sample(1, 1, 1, 1, 3500, -32767, 0, 0);
		send_sample(2, 1, 1, 1, 3500, 0, 0, 1);

		// idle with moving limits: faults and load toggling without leaving idle
		run_rounds(100, 0);
		set_limits(0, 32767, 0, -2048, 32767);
		run_rounds(100, 0);
		set_random_limits(32767);
		hold_asks <= hold_asks + 1;
		run_rounds(100, 0);
		set_limits(32767, 0, 32767, 2047, 32767);
		run_rounds(100, 0);

		// nothing can fault: leave idle and stay charging or discharging
		read_fail_pct = 0;
		set_limits(32767, 0, 32767, 2047,
			($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 3000));
		run_rounds(250, 0);

		// faults allowed again, the machine ends in fault
		read_fail_pct = 8;
		set_random_limits(0);
		run_rounds(200, 1);
		set_random_limits($urandom_range(0, 32767));
		run_rounds(180, 1);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d samples over idle, active and fault phases", items_sent);
		$display("%0d results checked, mode codes reached (one bit per code) %b",
			results_seen, modes_seen);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
